// ----- hdl/tmsp_pkg.sv -----
// shared constants, types and helpers for the three-motor stepper positioner
`default_nettype none

package tmsp_pkg;

    localparam int MOTOR_COUNT    = 3;
    localparam int MOTOR_IDX_W    = 2;
    localparam int ENCODER_COUNTS = 4096;
    localparam int ENC_HALF       = ENCODER_COUNTS / 2;

    typedef logic [1:0]         t_cmd;
    typedef logic [2:0]         t_reg_idx;
    typedef logic signed [17:0] t_err;
    typedef logic [16:0]        t_mag;
    typedef logic [16:0]        t_ticks;
    typedef logic signed [17:0] t_delay_sum;

    localparam t_cmd CMD_TICK = 2'd0;
    localparam t_cmd CMD_TURN = 2'd1;
    localparam t_cmd CMD_HOME = 2'd2;
    localparam t_cmd CMD_NOP  = 2'd3;

    localparam t_reg_idx REG_OUTER_BAND   = 3'd0;
    localparam t_reg_idx REG_INNER_BAND   = 3'd1;
    localparam t_reg_idx REG_RAMP_DIST    = 3'd2;
    localparam t_reg_idx REG_START_STEP   = 3'd3;
    localparam t_reg_idx REG_MIN_STEP     = 3'd4;
    localparam t_reg_idx REG_RAMP_INC     = 3'd5;

    localparam logic [11:0] RST_OUTER_BAND = 12'd20;
    localparam logic [11:0] RST_INNER_BAND = 12'd5;
    localparam logic [11:0] RST_RAMP_DIST  = 12'd200;
    localparam logic [15:0] RST_START_STEP = 16'd3000;
    localparam logic [15:0] RST_MIN_STEP   = 16'd1000;
    localparam logic [15:0] RST_RAMP_INC   = 16'd10;
    localparam logic [15:0] RST_DELAY      = 16'hFFFF;

    localparam t_ticks TICK_MAX = 17'h1FFFF;

    localparam t_err ERR_HALF   = t_err'(ENC_HALF);
    localparam t_err ERR_COUNTS = t_err'(ENCODER_COUNTS);

    // full-step coil sequence, bit0 is coil line 0
    function automatic logic [3:0] phase_coils(input logic [1:0] phase);
        logic [3:0] coils;
        case (phase)
            2'd0:    coils = 4'h5;
            2'd1:    coils = 4'h6;
            2'd2:    coils = 4'hA;
            2'd3:    coils = 4'h9;
            default: coils = 4'h0;
        endcase
        return coils;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tmsp_ifs.sv -----
// valid/ready channels for command items and drive results
`default_nettype none

interface tmsp_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [1:0]         motor_index;
    logic signed [15:0] turn_amount;
    logic signed [15:0] position_a;
    logic signed [15:0] position_b;
    logic signed [15:0] position_c;

    modport source (output valid, cmd, motor_index, turn_amount,
                    position_a, position_b, position_c, input ready);
    modport sink   (input valid, cmd, motor_index, turn_amount,
                    position_a, position_b, position_c, output ready);
endinterface

interface tmsp_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] coil_pattern;
    logic [2:0] enable_lines;
    logic [1:0] selected_motor;
    logic       stepped;
    logic       step_direction;
    logic       all_done;

    modport source (output valid, coil_pattern, enable_lines, selected_motor,
                    stepped, step_direction, all_done, input ready);
    modport sink   (input valid, coil_pattern, enable_lines, selected_motor,
                    stepped, step_direction, all_done, output ready);
endinterface

`default_nettype wire

// ----- hdl/three_motor_stepper_positioner.sv -----
// top level: closed-loop positioner driving three steppers on shared coil lines
//
// usage
//   i_req carries one command transaction: tick (three encoder positions),
//   turn (signed offset added to one motor's target, saturating) or home
//   (all targets to zero). every command transaction yields exactly one
//   transaction on o_rsp with the coil lines, the one-hot enable, the chosen
//   motor, the step flag, the direction and the all-done flag.
//   an apb-style port (register i at byte address 4*i) sets the bands, the
//   ramp distance, the delay ceiling and floor and the ramp increment; it is
//   to be written only while no command is in flight (the block does not enforce this).
// timing
//   a transaction is registered on entry, evaluated in one pass against the
//   motor state and registered on exit; one transaction per cycle is
//   sustained while o_rsp is not stalled. the per-motor state is read in the
//   evaluation and written at the edge that loads the result register.
// reset and stall
//   synchronous active-low reset clears targets, flags, phases, counters and
//   coils, sets every step delay to all ones and loads the register defaults.
//   while o_rsp is stalled the result holds; one more transaction is taken
//   into the entry register, then i_req.ready drops.
`default_nettype none

module three_motor_stepper_positioner (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tmsp_req_if.sink         i_req,
    tmsp_rsp_if.source       o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int MC = tmsp_pkg::MOTOR_COUNT;

    // configuration registers
    logic [11:0] r_outer_band;
    logic [11:0] r_inner_band;
    logic [11:0] r_ramp_dist;
    logic [15:0] r_start_step;
    logic [15:0] r_min_step;
    logic [15:0] r_ramp_inc;

    // entry register
    logic               r_in_valid;
    tmsp_pkg::t_cmd     r_in_cmd;
    logic [1:0]         r_in_motor_index;
    logic signed [15:0] r_in_turn_amount;
    logic signed [15:0] r_in_pos [MC];

    // motor state
    logic signed [15:0] r_target [MC];
    logic               r_active [MC];
    logic [1:0]         r_phase  [MC];
    logic [15:0]        r_delay  [MC];
    logic [tmsp_pkg::MOTOR_IDX_W-1:0] r_chosen;
    tmsp_pkg::t_ticks   r_ticks;
    logic [3:0]         r_coils;

    // next state
    logic signed [15:0] n_target [MC];
    logic               n_active [MC];
    logic [1:0]         n_phase  [MC];
    logic [15:0]        n_delay  [MC];
    logic [tmsp_pkg::MOTOR_IDX_W-1:0] n_chosen;
    tmsp_pkg::t_ticks   n_ticks;
    logic [3:0]         n_coils;
    logic               n_stepped;
    logic               n_dir;
    logic               n_all_done;

    // result register
    logic       r_out_valid;
    logic [3:0] r_out_coils;
    logic [2:0] r_out_enable;
    logic [1:0] r_out_selected;
    logic       r_out_stepped;
    logic       r_out_dir;
    logic       r_out_all_done;

    // evaluation temporaries
    logic                 advance;
    logic                 in_take;
    logic                 cfg_write;
    tmsp_pkg::t_err       diff    [MC];
    tmsp_pkg::t_err       err     [MC];
    tmsp_pkg::t_err       err_neg [MC];
    tmsp_pkg::t_mag       mag     [MC];
    logic                 biggest [MC];
    logic                 pick_found;
    logic                 any_active;
    logic [tmsp_pkg::MOTOR_IDX_W-1:0] pick;
    logic signed [15:0]   turn_base;
    logic signed [16:0]   turn_sum;
    tmsp_pkg::t_ticks     ticks_inc;
    tmsp_pkg::t_delay_sum delay_sum;
    logic [15:0]          delay_clamped;
    logic [1:0]           phase_next;

    // ---------------- handshake ----------------
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign in_take     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cmd         <= i_req.cmd;
            r_in_motor_index <= i_req.motor_index;
            r_in_turn_amount <= i_req.turn_amount;
            r_in_pos[0]      <= i_req.position_a;
            r_in_pos[1]      <= i_req.position_b;
            r_in_pos[2]      <= i_req.position_c;
        end
    end

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer_band <= tmsp_pkg::RST_OUTER_BAND;
            r_inner_band <= tmsp_pkg::RST_INNER_BAND;
            r_ramp_dist  <= tmsp_pkg::RST_RAMP_DIST;
            r_start_step <= tmsp_pkg::RST_START_STEP;
            r_min_step   <= tmsp_pkg::RST_MIN_STEP;
            r_ramp_inc   <= tmsp_pkg::RST_RAMP_INC;
        end else if (cfg_write) begin
            case (paddr[4:2])
                tmsp_pkg::REG_OUTER_BAND: r_outer_band <= pwdata[11:0];
                tmsp_pkg::REG_INNER_BAND: r_inner_band <= pwdata[11:0];
                tmsp_pkg::REG_RAMP_DIST:  r_ramp_dist  <= pwdata[11:0];
                tmsp_pkg::REG_START_STEP: r_start_step <= pwdata[15:0];
                tmsp_pkg::REG_MIN_STEP:   r_min_step   <= pwdata[15:0];
                tmsp_pkg::REG_RAMP_INC:   r_ramp_inc   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            tmsp_pkg::REG_OUTER_BAND: prdata = {20'd0, r_outer_band};
            tmsp_pkg::REG_INNER_BAND: prdata = {20'd0, r_inner_band};
            tmsp_pkg::REG_RAMP_DIST:  prdata = {20'd0, r_ramp_dist};
            tmsp_pkg::REG_START_STEP: prdata = {16'd0, r_start_step};
            tmsp_pkg::REG_MIN_STEP:   prdata = {16'd0, r_min_step};
            tmsp_pkg::REG_RAMP_INC:   prdata = {16'd0, r_ramp_inc};
            default:                  prdata = 32'd0;
        endcase
    end

    // ---------------- per-motor error and hysteresis ----------------
    always_comb begin
        for (int i = 0; i < MC; i++) begin
            diff[i] = {{2{r_target[i][15]}}, r_target[i]}
                    - {{2{r_in_pos[i][15]}}, r_in_pos[i]};
            // wrap once into the half-turn window
            if (diff[i] > tmsp_pkg::ERR_HALF) begin
                err[i] = diff[i] - tmsp_pkg::ERR_COUNTS;
            end else if (diff[i] < -tmsp_pkg::ERR_HALF) begin
                err[i] = diff[i] + tmsp_pkg::ERR_COUNTS;
            end else begin
                err[i] = diff[i];
            end
            err_neg[i] = -err[i];
            mag[i]     = err[i][17] ? err_neg[i][16:0] : err[i][16:0];
        end
    end

    // ---------------- motor selection ----------------
    // a motor wins if active and strictly larger than every later motor;
    // the lowest such index is taken
    always_comb begin
        pick_found = 1'b0;
        pick       = '0;
        any_active = 1'b0;
        for (int i = MC - 1; i >= 0; i--) begin
            if (r_in_cmd == tmsp_pkg::CMD_TICK) begin
                n_active[i] = r_active[i];
                if (mag[i] > {5'd0, r_outer_band}) begin
                    n_active[i] = 1'b1;
                end
                if (mag[i] < {5'd0, r_inner_band}) begin
                    n_active[i] = 1'b0;
                end
            end else begin
                n_active[i] = r_active[i];
            end
            any_active = any_active | n_active[i];
            biggest[i] = n_active[i];
            for (int j = i + 1; j < MC; j++) begin
                if (!(mag[i] > mag[j])) begin
                    biggest[i] = 1'b0;
                end
            end
            if (biggest[i]) begin
                pick_found = 1'b1;
                pick       = tmsp_pkg::MOTOR_IDX_W'(i);
            end
        end
    end

    // ---------------- ramp, step and command handling ----------------
    // target of the addressed motor, zero beyond the motor count
    always_comb begin
        turn_base = '0;
        for (int k = 0; k < MC; k++) begin
            if (r_in_motor_index == 2'(k)) begin
                turn_base = r_target[k];
            end
        end
    end

    assign turn_sum  = {turn_base[15], turn_base}
                     + {r_in_turn_amount[15], r_in_turn_amount};
    assign ticks_inc = (r_ticks < tmsp_pkg::TICK_MAX) ? r_ticks + 17'd1 : r_ticks;

    always_comb begin
        if (mag[pick] > {5'd0, r_ramp_dist}) begin
            delay_sum = {2'b00, r_delay[pick]} - {2'b00, r_ramp_inc};
        end else begin
            delay_sum = {2'b00, r_delay[pick]} + {2'b00, r_ramp_inc};
        end
        // floor wins over ceiling
        if (delay_sum < $signed({2'b00, r_min_step})) begin
            delay_clamped = r_min_step;
        end else if (delay_sum > $signed({2'b00, r_start_step})) begin
            delay_clamped = (r_start_step < r_min_step) ? r_min_step : r_start_step;
        end else begin
            delay_clamped = delay_sum[15:0];
        end
        phase_next = r_phase[pick] + (err[pick][17] ? 2'd1 : 2'd3);
    end

    always_comb begin
        for (int i = 0; i < MC; i++) begin
            n_target[i] = r_target[i];
            n_phase[i]  = r_phase[i];
            n_delay[i]  = r_delay[i];
        end
        n_chosen   = r_chosen;
        n_ticks    = r_ticks;
        n_coils    = r_coils;
        n_stepped  = 1'b0;
        n_dir      = 1'b0;
        n_all_done = !any_active;

        case (r_in_cmd)
            tmsp_pkg::CMD_TURN: begin
                for (int i = 0; i < MC; i++) begin
                    if (r_in_motor_index == 2'(i)) begin
                        if (turn_sum[16] != turn_sum[15]) begin
                            n_target[i] = turn_sum[16] ? 16'sh8000 : 16'sh7FFF;
                        end else begin
                            n_target[i] = turn_sum[15:0];
                        end
                        n_ticks = '0;
                    end
                end
            end
            tmsp_pkg::CMD_HOME: begin
                for (int i = 0; i < MC; i++) begin
                    n_target[i] = '0;
                end
            end
            tmsp_pkg::CMD_TICK: begin
                n_ticks = ticks_inc;
                if (!any_active || !pick_found) begin
                    n_coils = 4'h0;
                end else begin
                    n_chosen       = pick;
                    n_dir          = err[pick][17];
                    n_delay[pick]  = delay_clamped;
                    if (ticks_inc > {1'b0, delay_clamped}) begin
                        n_ticks        = '0;
                        n_phase[pick]  = phase_next;
                        n_coils        = tmsp_pkg::phase_coils(phase_next);
                        n_stepped      = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MC; i++) begin
                r_target[i] <= '0;
                r_active[i] <= 1'b0;
                r_phase[i]  <= '0;
                r_delay[i]  <= tmsp_pkg::RST_DELAY;
            end
            r_chosen <= '0;
            r_ticks  <= '0;
            r_coils  <= '0;
        end else if (advance) begin
            for (int i = 0; i < MC; i++) begin
                r_target[i] <= n_target[i];
                r_active[i] <= n_active[i];
                r_phase[i]  <= n_phase[i];
                r_delay[i]  <= n_delay[i];
            end
            r_chosen <= n_chosen;
            r_ticks  <= n_ticks;
            r_coils  <= n_coils;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_coils    <= n_coils;
            r_out_enable   <= 3'b001 << n_chosen;
            r_out_selected <= n_chosen;
            r_out_stepped  <= n_stepped;
            r_out_dir      <= n_dir;
            r_out_all_done <= n_all_done;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.coil_pattern   = r_out_coils;
    assign o_rsp.enable_lines   = r_out_enable;
    assign o_rsp.selected_motor = r_out_selected;
    assign o_rsp.stepped        = r_out_stepped;
    assign o_rsp.step_direction = r_out_dir;
    assign o_rsp.all_done       = r_out_all_done;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// self-checking testbench for the three-motor stepper positioner: directed table, random phases
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MOTOR_COUNT = tmsp_pkg::MOTOR_COUNT;

    // one command transaction as it goes into the block
    typedef struct packed {
        tmsp_pkg::t_cmd     cmd;
        logic [1:0]         motor_index;
        logic signed [15:0] turn_amount;
        logic signed [15:0] position_a;
        logic signed [15:0] position_b;
        logic signed [15:0] position_c;
    } t_cmd_item;

    // one drive result as it comes out of the block
    typedef struct packed {
        logic [3:0] coil_pattern;
        logic [2:0] enable_lines;
        logic [1:0] selected_motor;
        logic       stepped;
        logic       step_direction;
        logic       all_done;
    } t_drive;

    // directed row: the command and, where it is obvious, the drive it must give
    typedef struct packed {
        t_cmd_item item;
        logic      typed;
        t_drive    want;
    } t_directed_row;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 10;

    localparam tmsp_pkg::t_cmd CMD_TICK = tmsp_pkg::CMD_TICK;
    localparam tmsp_pkg::t_cmd CMD_TURN = tmsp_pkg::CMD_TURN;
    localparam tmsp_pkg::t_cmd CMD_HOME = tmsp_pkg::CMD_HOME;
    localparam tmsp_pkg::t_cmd CMD_NOP  = tmsp_pkg::CMD_NOP;

    // full-step coil order, bit0 is coil line 0
    localparam logic [3:0] COIL_SEQ [4] = '{4'h5, 4'h6, 4'hA, 4'h9};

    localparam t_drive AT_REST = '{coil_pattern: 4'h0, enable_lines: 3'b001,
                                   selected_motor: 2'd0, stepped: 1'b0,
                                   step_direction: 1'b0, all_done: 1'b1};
    localparam t_drive UNTYPED = '0;

    // directed part, run with the register defaults
    localparam t_directed_row DIRECTED_ROWS [19] = '{
        // right after reset: no error anywhere, coils off
        '{'{CMD_TICK, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, AT_REST},
        // unused command code with every field busy is ignored
        '{'{CMD_NOP,  2'd3, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h5555}, 1'b1, AT_REST},
        // turn on a motor index that does not exist is ignored
        '{'{CMD_TURN, 2'd3, 16'h0064, 16'h0000, 16'h0000, 16'h0000}, 1'b1, AT_REST},
        // target add up to the top, then saturating there
        '{'{CMD_TURN, 2'd0, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000}, 1'b1, AT_REST},
        '{'{CMD_TURN, 2'd0, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000}, 1'b1, AT_REST},
        // target add down to the bottom, then saturating there
        '{'{CMD_TURN, 2'd1, 16'h8000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, AT_REST},
        '{'{CMD_TURN, 2'd1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000}, 1'b1, AT_REST},
        // encoders sit on the saturated targets
        '{'{CMD_TICK, 2'd0, 16'h0000, 16'h7FFF, 16'h8000, 16'h0000}, 1'b1, AT_REST},
        // error of exactly half a turn is not folded
        '{'{CMD_TICK, 2'd0, 16'h0000, 16'h77FF, 16'h8000, 16'h0000}, 1'b0, UNTYPED},
        // one count past half a turn folds negative, direction without a step
        '{'{CMD_TICK, 2'd0, 16'h0000, 16'h77FE, 16'h8000, 16'h0000}, 1'b0, UNTYPED},
        // equal magnitudes on motors 0 and 1: the later one wins the tie
        '{'{CMD_TICK, 2'd0, 16'h0000, 16'h77FE, 16'h8801, 16'h0000}, 1'b0, UNTYPED},
        // raw error far beyond one turn is folded only once
        '{'{CMD_TICK, 2'd0, 16'h0000, 16'h8000, 16'h8801, 16'h0000}, 1'b0, UNTYPED},
        '{'{CMD_HOME, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, UNTYPED},
        // all errors zero: every active flag clears
        '{'{CMD_TICK, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, UNTYPED},
        '{'{CMD_TICK, 2'd0, 16'h0000, 16'hFF9C, 16'hFF9C, 16'h0000}, 1'b0, UNTYPED},
        // active motors but none strictly largest and the last one idle
        '{'{CMD_TICK, 2'd0, 16'h0000, 16'hFFF6, 16'hFFF6, 16'hFFF1}, 1'b0, UNTYPED},
        // only the last motor active: it is chosen
        '{'{CMD_TICK, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'hFFE2}, 1'b0, UNTYPED},
        '{'{CMD_TURN, 2'd2, 16'h0010, 16'h0000, 16'h0000, 16'h0000}, 1'b0, UNTYPED},
        '{'{CMD_TICK, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0010}, 1'b0, UNTYPED}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tmsp_req_if req_if ();
    tmsp_rsp_if rsp_if ();

    three_motor_stepper_positioner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // register copies seen by the predictor
    logic [11:0] cfg_outer;
    logic [11:0] cfg_inner;
    logic [11:0] cfg_ramp;
    logic [15:0] cfg_start;
    logic [15:0] cfg_min;
    logic [15:0] cfg_inc;

    // positioner state kept by the predictor
    logic signed [15:0] target_pos   [MOTOR_COUNT];
    bit                 motor_active [MOTOR_COUNT];
    logic [1:0]         motor_phase  [MOTOR_COUNT];
    logic [15:0]        motor_delay  [MOTOR_COUNT];
    logic [1:0]         drive_motor;
    tmsp_pkg::t_ticks   step_ticks;
    logic [3:0]         coil_lines;

    // simulated shafts: a step moves the chosen shaft toward its target
    logic signed [15:0] shaft_pos [MOTOR_COUNT];

    t_drive expected_drives [$];
    int     error_count = 0;
    int     cycle_count = 0;
    bit     no_idle     = 1'b0;

    // clock: 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side back-pressure, off during quiet stretches
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_if.ready = no_idle || ($urandom_range(0, 99) >= 6);
        end
    end

    // works out the drive result of one command and updates the state
    function automatic t_drive advance_positioner(input t_cmd_item it);
        t_drive r;
        int     pos [MOTOR_COUNT];
        int     err [MOTOR_COUNT];
        int     mag [MOTOR_COUNT];
        int     sum;
        int     dly;
        int     pick;
        bit     biggest;
        bit     any_active;
        bit     took_step;
        bit     forward;
        took_step = 1'b0;
        forward   = 1'b0;
        pos[0]    = $signed(it.position_a);
        pos[1]    = $signed(it.position_b);
        pos[2]    = $signed(it.position_c);
        case (it.cmd)
            CMD_TURN: begin
                if (it.motor_index < MOTOR_COUNT) begin
                    sum = int'(target_pos[it.motor_index]) + int'($signed(it.turn_amount));
                    if (sum > 32767)
                        sum = 32767;
                    if (sum < -32768)
                        sum = -32768;
                    target_pos[it.motor_index] = 16'(sum);
                    step_ticks = '0;
                end
            end
            CMD_HOME: begin
                foreach (target_pos[i])
                    target_pos[i] = '0;
            end
            CMD_TICK: begin
                // error per motor, folded once, then hysteresis with clear last
                for (int i = 0; i < MOTOR_COUNT; i++) begin
                    err[i] = int'(target_pos[i]) - pos[i];
                    if (err[i] > tmsp_pkg::ENC_HALF)
                        err[i] -= tmsp_pkg::ENCODER_COUNTS;
                    else if (err[i] < -tmsp_pkg::ENC_HALF)
                        err[i] += tmsp_pkg::ENCODER_COUNTS;
                    mag[i] = (err[i] < 0) ? -err[i] : err[i];
                    if (mag[i] > int'(cfg_outer))
                        motor_active[i] = 1'b1;
                    if (mag[i] < int'(cfg_inner))
                        motor_active[i] = 1'b0;
                end
                if (step_ticks < tmsp_pkg::TICK_MAX)
                    step_ticks++;
                // first active motor strictly larger than every later one
                pick = -1;
                for (int i = 0; i < MOTOR_COUNT && pick < 0; i++) begin
                    biggest = motor_active[i];
                    for (int j = i + 1; j < MOTOR_COUNT; j++)
                        if (mag[i] <= mag[j])
                            biggest = 1'b0;
                    if (biggest)
                        pick = i;
                end
                if (pick < 0) begin
                    coil_lines = '0;
                end else begin
                    drive_motor = 2'(pick);
                    forward     = (err[pick] < 0);
                    if (mag[pick] > int'(cfg_ramp))
                        dly = int'(motor_delay[pick]) - int'(cfg_inc);
                    else
                        dly = int'(motor_delay[pick]) + int'(cfg_inc);
                    if (dly > int'(cfg_start))
                        dly = int'(cfg_start);
                    if (dly < int'(cfg_min))
                        dly = int'(cfg_min);
                    motor_delay[pick] = 16'(dly);
                    if (int'(step_ticks) > dly) begin
                        step_ticks = '0;
                        if (forward)
                            motor_phase[pick] = motor_phase[pick] + 2'd1;
                        else
                            motor_phase[pick] = motor_phase[pick] - 2'd1;
                        coil_lines = COIL_SEQ[motor_phase[pick]];
                        took_step  = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        any_active = 1'b0;
        foreach (motor_active[i])
            any_active |= motor_active[i];
        r.coil_pattern   = coil_lines;
        r.enable_lines   = 3'(1 << drive_motor);
        r.selected_motor = drive_motor;
        r.stepped        = took_step;
        r.step_direction = took_step ? forward : (it.cmd == CMD_TICK && forward);
        r.all_done       = !any_active;
        return r;
    endfunction

    // mostly encoder ticks that track the simulated shafts, some noise
    function automatic t_cmd_item random_command();
        t_cmd_item          it;
        logic signed [15:0] enc [MOTOR_COUNT];
        int                 kind;
        int                 size_class;
        foreach (enc[i])
            enc[i] = shaft_pos[i];
        it.cmd         = CMD_TICK;
        it.motor_index = 2'($urandom_range(0, 3));
        it.turn_amount = 16'($urandom);
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            foreach (enc[i])
                if ($urandom_range(0, 99) < 15)
                    enc[i] = enc[i] + 16'($urandom_range(0, 6)) - 16'd3;
        end else if (kind < 80) begin
            foreach (enc[i])
                enc[i] = 16'($urandom);
        end else if (kind < 82) begin
            // readings around the fold point
            foreach (enc[i])
                if ($urandom_range(0, 1) != 0)
                    enc[i] = target_pos[i] - 16'($urandom_range(2040, 2056));
                else
                    enc[i] = target_pos[i] + 16'($urandom_range(2040, 2056));
        end else if (kind < 94) begin
            it.cmd = CMD_TURN;
            size_class = $urandom_range(0, 99);
            if (size_class < 70)
                it.turn_amount = 16'($urandom_range(0, 600)) - 16'd300;
            else if (size_class < 90)
                it.turn_amount = 16'($urandom_range(0, 6000)) - 16'd3000;
        end else if (kind < 97) begin
            it.cmd = CMD_HOME;
        end else begin
            it.cmd = CMD_NOP;
        end
        it.position_a = enc[0];
        it.position_b = enc[1];
        it.position_c = enc[2];
        return it;
    endfunction

    // one register write: setup cycle, then access cycle until pready
    task automatic write_register(input tmsp_pkg::t_reg_idx idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            tmsp_pkg::REG_OUTER_BAND: cfg_outer = value[11:0];
            tmsp_pkg::REG_INNER_BAND: cfg_inner = value[11:0];
            tmsp_pkg::REG_RAMP_DIST:  cfg_ramp  = value[11:0];
            tmsp_pkg::REG_START_STEP: cfg_start = value[15:0];
            tmsp_pkg::REG_MIN_STEP:   cfg_min   = value[15:0];
            tmsp_pkg::REG_RAMP_INC:   cfg_inc   = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_registers(input logic [11:0] outer, input logic [11:0] inner,
                                 input logic [11:0] ramp, input logic [15:0] start_time,
                                 input logic [15:0] min_time, input logic [15:0] inc);
        write_register(tmsp_pkg::REG_OUTER_BAND, 32'(outer));
        write_register(tmsp_pkg::REG_INNER_BAND, 32'(inner));
        write_register(tmsp_pkg::REG_RAMP_DIST,  32'(ramp));
        write_register(tmsp_pkg::REG_START_STEP, 32'(start_time));
        write_register(tmsp_pkg::REG_MIN_STEP,   32'(min_time));
        write_register(tmsp_pkg::REG_RAMP_INC,   32'(inc));
    endtask

    // drives one command transaction; its drive result is predicted on acceptance
    task automatic send_command(input t_cmd_item it, input logic typed, input t_drive want);
        t_drive             predicted;
        logic signed [15:0] gear;
        while (!no_idle && $urandom_range(0, 99) < 6) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid       = 1'b1;
        req_if.cmd         = it.cmd;
        req_if.motor_index = it.motor_index;
        req_if.turn_amount = it.turn_amount;
        req_if.position_a  = it.position_a;
        req_if.position_b  = it.position_b;
        req_if.position_c  = it.position_c;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        predicted = advance_positioner(it);
        expected_drives.push_back(typed ? want : predicted);
        // the stepped shaft moves a few encoder counts toward its target
        if (predicted.stepped) begin
            gear = 16'($urandom_range(1, 4));
            if (predicted.step_direction)
                shaft_pos[predicted.selected_motor] -= gear;
            else
                shaft_pos[predicted.selected_motor] += gear;
        end
        @(negedge i_clk);
    endtask

    // random commands; ignored ones do not count, no idling inside the calm window
    task automatic run_random(input int count, input int calm_from, input int calm_to);
        t_cmd_item it;
        int        n;
        n = 0;
        while (n < count) begin
            no_idle = (n >= calm_from && n < calm_to);
            it = random_command();
            send_command(it, 1'b0, UNTYPED);
            if (!(it.cmd == CMD_NOP || (it.cmd == CMD_TURN && it.motor_index >= MOTOR_COUNT)))
                n++;
        end
        no_idle = 1'b0;
    endtask

    // block goes idle: wait for every expected result, then for the settle slack
    task automatic settle();
        int waited;
        req_if.valid = 1'b0;
        waited = 0;
        while (expected_drives.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_drives.size() != 0) begin
            $error("%0d drive results never arrived", expected_drives.size());
            error_count++;
            expected_drives.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // compare every accepted drive transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_drive want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_drives.size() == 0) begin
                $error("drive result with nothing expected");
                error_count++;
            end else begin
                want = expected_drives.pop_front();
                if (rsp_if.coil_pattern !== want.coil_pattern) begin
                    $error("coil_pattern expected %h got %h",
                           want.coil_pattern, rsp_if.coil_pattern);
                    error_count++;
                end
                if (rsp_if.enable_lines !== want.enable_lines) begin
                    $error("enable_lines expected %b got %b",
                           want.enable_lines, rsp_if.enable_lines);
                    error_count++;
                end
                if (rsp_if.selected_motor !== want.selected_motor) begin
                    $error("selected_motor expected %0d got %0d",
                           want.selected_motor, rsp_if.selected_motor);
                    error_count++;
                end
                if (rsp_if.stepped !== want.stepped) begin
                    $error("stepped expected %b got %b", want.stepped, rsp_if.stepped);
                    error_count++;
                end
                if (rsp_if.step_direction !== want.step_direction) begin
                    $error("step_direction expected %b got %b",
                           want.step_direction, rsp_if.step_direction);
                    error_count++;
                end
                if (rsp_if.all_done !== want.all_done) begin
                    $error("all_done expected %b got %b", want.all_done, rsp_if.all_done);
                    error_count++;
                end
            end
        end
    end

    initial begin
        // every input known from time zero, reset held
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.cmd         = CMD_TICK;
        req_if.motor_index = '0;
        req_if.turn_amount = '0;
        req_if.position_a  = '0;
        req_if.position_b  = '0;
        req_if.position_c  = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;

        // predictor matches the block after reset
        cfg_outer = tmsp_pkg::RST_OUTER_BAND;
        cfg_inner = tmsp_pkg::RST_INNER_BAND;
        cfg_ramp  = tmsp_pkg::RST_RAMP_DIST;
        cfg_start = tmsp_pkg::RST_START_STEP;
        cfg_min   = tmsp_pkg::RST_MIN_STEP;
        cfg_inc   = tmsp_pkg::RST_RAMP_INC;
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            target_pos[i]   = '0;
            motor_active[i] = 1'b0;
            motor_phase[i]  = '0;
            motor_delay[i]  = tmsp_pkg::RST_DELAY;
            shaft_pos[i]    = '0;
        end
        drive_motor = '0;
        step_ticks  = '0;
        coil_lines  = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table with the register defaults
        foreach (DIRECTED_ROWS[k])
            send_command(DIRECTED_ROWS[k].item, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);
        settle();

        // short delays so the motors step and chase their targets, with a calm stretch
        set_registers(12'd20, 12'd5, 12'd40, 16'd12, 16'd2, 16'd1);
        run_random(300, 100, 250);
        settle();

        // low extremes: any error activates, nothing clears, a step on every tick that chooses a motor
        set_registers(12'd0, 12'd0, 12'd1, 16'd0, 16'd0, 16'd0);
        run_random(200, 0, 0);
        settle();

        // high extremes: only unfolded far errors activate, longest delays
        set_registers(12'd2048, 12'd2048, 12'd2048, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(100, 0, 0);
        settle();

        // floor above ceiling with a huge increment, inner band above outer band
        set_registers(12'd50, 12'd60, 12'd100, 16'd5, 16'd30, 16'hFFFF);
        run_random(200, 0, 0);
        settle();

        // random settings around the working range
        repeat (3) begin
            set_registers(12'($urandom_range(0, 300)), 12'($urandom_range(0, 300)),
                          12'($urandom_range(1, 400)), 16'($urandom_range(0, 40)),
                          16'($urandom_range(0, 40)), 16'($urandom_range(0, 20)));
            run_random(200, 0, 0);
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
